/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that expr holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// check that cons holds in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/b64e_pkg.sv */
`timescale 1ns / 1ps

package b64e_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	typedef enum logic [2:0] {
		PH0 = 3'b001,
		PH1 = 3'b010,
		PH2 = 3'b100
	} phase_t;

	typedef struct packed {
		logic [3:0][7:0] chars;
		logic [1:0]      last_idx;
		logic            last;
	} entry_t;

	function automatic logic [7:0] sextet_char(input logic [5:0] s);
		logic [7:0] v;
		v = {2'b00, s};
		if (s < 6'd26) begin
			return v + 8'h41;
		end else if (s < 6'd52) begin
			return v + 8'h47;
		end else if (s < 6'd62) begin
			return v - 8'h04;
		end else if (s == 6'd62) begin
			return 8'h2B;
		end else begin
			return 8'h2F;
		end
	endfunction

endpackage

/* hw/rtl/b64e_front.sv */
`timescale 1ns / 1ps

module b64e_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  logic              q_full,
	output logic              push,
	output b64e_pkg::entry_t  push_ent
);

	b64e_pkg::phase_t phase_q;
	b64e_pkg::phase_t phase_nxt;
	logic [7:0]       prev_q;

	assign byte_stall = q_full;
	assign push       = byte_valid && !q_full;

	always_comb begin
		push_ent.chars    = {4{b64e_pkg::PAD_CHAR}};
		push_ent.last_idx = 2'd0;
		push_ent.last     = last_byte;
		unique case (phase_q)
			b64e_pkg::PH1: begin
				push_ent.chars[0] = b64e_pkg::sextet_char({prev_q[1:0], data_byte[7:4]});
				push_ent.chars[1] = b64e_pkg::sextet_char({data_byte[3:0], 2'b00});
				push_ent.last_idx = last_byte ? 2'd2 : 2'd0;
				phase_nxt         = b64e_pkg::PH2;
			end
			b64e_pkg::PH2: begin
				push_ent.chars[0] = b64e_pkg::sextet_char({prev_q[3:0], data_byte[7:6]});
				push_ent.chars[1] = b64e_pkg::sextet_char(data_byte[5:0]);
				push_ent.last_idx = 2'd1;
				phase_nxt         = b64e_pkg::PH0;
			end
			default: begin
				push_ent.chars[0] = b64e_pkg::sextet_char(data_byte[7:2]);
				push_ent.chars[1] = b64e_pkg::sextet_char({data_byte[1:0], 4'b0000});
				push_ent.last_idx = last_byte ? 2'd3 : 2'd0;
				phase_nxt         = b64e_pkg::PH1;
			end
		endcase
		if (last_byte) begin
			phase_nxt = b64e_pkg::PH0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= b64e_pkg::PH0;
		end else if (push) begin
			phase_q <= phase_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			prev_q <= data_byte;
		end
	end

endmodule

/* hw/rtl/b64e_fifo.sv */
`timescale 1ns / 1ps

`include "assert_macros.svh"

module b64e_fifo #(
	parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  b64e_pkg::entry_t push_ent,
	input  logic             pop,
	output logic             full,
	output logic             q_valid,
	output b64e_pkg::entry_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	b64e_pkg::entry_t mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;

	assign full    = cnt_q == CW'(DEPTH);
	assign q_valid = cnt_q != '0;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_ent;
		end
	end

	`ASSERT_ALWAYS(a_cnt_bound, clk, arst_n, cnt_q <= CW'(DEPTH), "queue count beyond depth")
	`ASSERT_ALWAYS(a_no_overflow, clk, arst_n, !(push && full), "write into full queue")
	`ASSERT_ALWAYS(a_no_underflow, clk, arst_n, !(pop && !q_valid), "read from empty queue")

endmodule

/* hw/rtl/b64e_back.sv */
`timescale 1ns / 1ps

`include "assert_macros.svh"

module b64e_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  b64e_pkg::entry_t head,
	output logic             pop,
	output logic             char_valid,
	input  logic             char_stall,
	output logic [7:0]       out_char,
	output logic             last_char
);

	b64e_pkg::entry_t ent_q;
	logic             busy_q;
	logic [1:0]       idx_q;
	logic             char_valid_q;
	logic [7:0]       char_q;
	logic             last_q;
	logic             out_free;
	logic             done;

	assign out_free = !char_valid_q || !char_stall;
	assign done     = idx_q == ent_q.last_idx;
	assign pop      = q_valid && (!busy_q || (out_free && done));

	assign char_valid = char_valid_q;
	assign out_char   = char_q;
	assign last_char  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			idx_q        <= '0;
			char_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q && out_free) begin
				if (done) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (out_free) begin
				char_valid_q <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= head;
		end
		if (busy_q && out_free) begin
			char_q <= ent_q.chars[idx_q];
			last_q <= ent_q.last && done;
		end
	end

	`ASSERT_ALWAYS(a_idx_bound, clk, arst_n, !(busy_q && idx_q > ent_q.last_idx), "index past entry")
	`ASSERT_NEXT(a_pop_load, clk, arst_n, pop, busy_q && idx_q == 2'd0, "entry not loaded")
	`ASSERT_NEXT(a_emit, clk, arst_n, busy_q && out_free, char_valid_q, "character not emitted")

endmodule

/* hw/rtl/base64_stream_encoder.sv */
`timescale 1ns / 1ps

// Streaming Base64 encoder, standard alphabet with '=' padding.
// Input channel: one raw byte per transfer (data_byte), last_byte marks the
// final byte of a message and triggers the flush of leftover bits and padding.
// Output channel: one ASCII character per transfer (out_char); last_char is
// set on the final character of each encoded message.
// Both channels transfer when valid is high and stall is low.
// A byte yields 1 to 4 characters. Its entry passes the queue and the
// sequencer's entry register before its first character reaches the output.
// The output register sends at most one character per cycle, which sets the
// throughput: each group of 3 bytes yields 4 characters.
// Bytes are taken every cycle while the entry queue between the classifier
// and the character sequencer has room (QUEUE_DEPTH entries).
// When the receiver stalls, the current character holds, the sequencer
// freezes, and byte_stall rises once the queue fills.
// Reset clears the group phase, the queue and the output valid.
module base64_stream_encoder #(
	parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       char_valid,
	input  logic       char_stall,
	output logic [7:0] out_char,
	output logic       last_char
);

	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_valid;
	b64e_pkg::entry_t push_ent;
	b64e_pkg::entry_t head;

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.q_full     (q_full),
		.push       (push),
		.push_ent   (push_ent)
	);

	b64e_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.pop      (pop),
		.full     (q_full),
		.q_valid  (q_valid),
		.head     (head)
	);

	b64e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.head       (head),
		.pop        (pop),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.out_char   (out_char),
		.last_char  (last_char)
	);

endmodule
